>>> src/nbfa_pkg.sv
// Package for the nursery bump/fragment allocator.
// Request kinds, status codes, register indexes and fixed field widths.
// No dependencies.
`default_nettype none
package nbfa_pkg;
   localparam int ADDR_W    = 48;
   localparam int PAYLOAD_W = 16;
   localparam int TAG_W     = 16;
   localparam int SC_W      = 14;
   localparam int NS_W      = 25;
   localparam int TOT_W     = 17;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_PIN   = 2'd1;
   localparam logic [1:0] REQ_UNPIN = 2'd2;
   localparam logic [1:0] REQ_RESET = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_OUTSIDE = 2'd3;

   localparam logic CSR_HEAP_BASE    = 1'b0;
   localparam logic CSR_NURSERY_SIZE = 1'b1;
endpackage
`default_nettype wire

>>> src/nursery_bump_fragment_allocator_unit.sv
// Nursery allocator top level: sequencer, state registers and result register.
// Depends on nbfa_pkg and nbfa_ram.
//
// One item is worked at a time; the result register lets the next item enter
// while a result waits. Bump allocate, allocate with no fragments, failed
// pin/unpin range check and a reset with nothing pinned go straight to the
// result. A fragment scan reads and checks one entry after another, and shifts
// the later entries down when a used-up fragment is removed. A pin or unpin
// searches the pinned entries one after another; a search that finds no match,
// or a pin or unpin with an empty table, passes through a miss state. An unpin
// that finds its entry shifts the later entries down. A reset with N pinned
// regions runs a selection pass over the pinned table, N rounds of N reads plus
// one apply step each, and finishes with a tail step. Each table memory has a
// single registered read port, one entry per read. A result held by rsp_tready
// low stalls the sequencer in its final state. Configuration writes are taken
// at any time, csr_ready is always high, and must only be made while the block
// is idle.
`default_nettype none
module nursery_bump_fragment_allocator_unit #(
   parameter int HEADER_BYTES  = 16,
   parameter int MAX_PINNED    = 16,
   parameter int MAX_FRAGMENTS = 17,
   parameter int OFFSET_BITS   = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // item in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // payload_bytes, type_tag, object_address, object size class, 2 zero bits
   input  wire logic [95:0] req_tdata,
   // req_type
   input  wire logic [1:0]  req_tuser,
   // result out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // payload_address, header_address, size_class_out, type_tag_out,
   // used_bytes, from_fragment, zero fill
   output logic [((2*48 + 14 + 16 + OFFSET_BITS + 1 + 7) / 8) * 8 - 1:0] rsp_tdata,
   // status
   output logic [1:0]       rsp_tuser,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [47:0] csr_data
);
   localparam int OB      = OFFSET_BITS;
   localparam int AW      = nbfa_pkg::ADDR_W;
   localparam int SCW     = nbfa_pkg::SC_W;
   localparam int TW      = nbfa_pkg::TOT_W;
   localparam int NSW     = nbfa_pkg::NS_W;
   localparam int SUMW    = ((OB > TW) ? OB : TW) + 1;
   localparam int CW      = (OB > NSW) ? OB : NSW;
   localparam int FIDX_W  = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam int PIDX_W  = (MAX_PINNED > 1) ? $clog2(MAX_PINNED) : 1;
   localparam int FCNT_W  = $clog2(MAX_FRAGMENTS + 1);
   localparam int PCNT_W  = $clog2(MAX_PINNED + 1);
   localparam int IW      = (FCNT_W > PCNT_W) ? FCNT_W : PCNT_W;
   localparam int FRAG_W  = 2 * OB;
   localparam int PIN_W   = OB + SCW;
   localparam int DATA_W  = 2 * AW + SCW + nbfa_pkg::TAG_W + OB + 1;
   localparam int RSP_W   = ((DATA_W + 7) / 8) * 8;
   localparam logic [OB-1:0] OFF_MASK = {OB{1'b1}};
   localparam logic [OB-1:0] MIN_FRAG = OB'(HEADER_BYTES + 8);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_FR_RD    = 4'd1;
   localparam logic [3:0] S_FR_CHK   = 4'd2;
   localparam logic [3:0] S_FR_MV_RD = 4'd3;
   localparam logic [3:0] S_FR_MV_WR = 4'd4;
   localparam logic [3:0] S_PN_RD    = 4'd5;
   localparam logic [3:0] S_PN_CHK   = 4'd6;
   localparam logic [3:0] S_PN_MV_RD = 4'd7;
   localparam logic [3:0] S_PN_MV_WR = 4'd8;
   localparam logic [3:0] S_PN_MISS  = 4'd9;
   localparam logic [3:0] S_RS_RD    = 4'd10;
   localparam logic [3:0] S_RS_CHK   = 4'd11;
   localparam logic [3:0] S_RS_APPLY = 4'd12;
   localparam logic [3:0] S_RS_TAIL  = 4'd13;
   localparam logic [3:0] S_DONE     = 4'd14;

   // saturating add into the used count
   function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a,
                                             input logic [TW-1:0] b);
      logic [SUMW-1:0] s;
      s = SUMW'(a) + SUMW'(b);
      return (s > SUMW'(OFF_MASK)) ? OFF_MASK : s[OB-1:0];
   endfunction

   logic [3:0]      state_ff, state_in;
   logic [AW-1:0]   heap_base_ff, heap_base_in;
   logic [NSW-1:0]  nursery_size_ff, nursery_size_in;
   logic [OB-1:0]   bump_off_ff, bump_off_in;
   logic [OB-1:0]   used_ff, used_in;
   logic            bump_en_ff, bump_en_in;
   logic [FCNT_W-1:0] fcnt_ff, fcnt_in;
   logic [PCNT_W-1:0] pcnt_ff, pcnt_in;

   // latched item
   logic [1:0]      op_ff, op_in;
   logic [TW-1:0]   total_ff, total_in;
   logic [15:0]     tag_ff, tag_in;
   logic [OB-1:0]   pstart_ff, pstart_in;
   logic [SCW-1:0]  psc_ff, psc_in;

   // scan / rebuild working registers
   logic [IW-1:0]   idx_ff, idx_in;
   logic [PCNT_W-1:0] round_ff, round_in;
   logic [SUMW-1:0] prev_ff, prev_in;
   logic [OB-1:0]   sum_ff, sum_in;
   logic [OB-1:0]   last_ff, last_in;
   logic            have_last_ff, have_last_in;
   logic            best_v_ff, best_v_in;
   logic [OB-1:0]   best_start_ff, best_start_in;
   logic [SCW-1:0]  best_sc_ff, best_sc_in;
   logic [OB-1:0]   first_start_ff, first_start_in;

   // pending result
   logic [1:0]      res_status_ff, res_status_in;
   logic [OB-1:0]   res_off_ff, res_off_in;
   logic            res_ok_ff, res_ok_in;
   logic            res_frag_ff, res_frag_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]      rsp_user_ff, rsp_user_in;

   // memory ports
   logic              f_we;
   logic [FIDX_W-1:0] f_waddr, f_raddr;
   logic [FRAG_W-1:0] f_wdata, f_rdata;
   logic              p_we;
   logic [PIDX_W-1:0] p_waddr, p_raddr;
   logic [PIN_W-1:0]  p_wdata, p_rdata;

   nbfa_ram #(.WIDTH(FRAG_W), .DEPTH(MAX_FRAGMENTS)) u_frag_ram (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rdata)
   );

   nbfa_ram #(.WIDTH(PIN_W), .DEPTH(MAX_PINNED)) u_pin_ram (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata(p_rdata)
   );

   // combinational views
   logic [OB-1:0]   cap;
   logic            req_fire;
   logic [15:0]     req_payload;
   logic [AW-1:0]   req_addr;
   logic [SCW-1:0]  req_sc;
   logic [TW-1:0]   req_total;
   logic            bump_fit;
   logic            addr_above;
   logic [AW-1:0]   pin_start;
   logic [AW:0]     pin_end;
   logic            pin_inside;
   logic [OB-1:0]   fr_start, fr_size, fr_nsize;
   logic [OB-1:0]   pn_start, rs_cand;
   logic [IW-1:0]   idx_nx, idx_m1;
   logic [TW-1:0]   best_len;
   logic [SUMW-1:0] best_end;
   logic [OB-1:0]   gap;
   logic [OB-1:0]   tail_size;
   logic            tail_add;
   logic [AW-1:0]   out_hdr, out_pay;

   assign cap = (CW'(nursery_size_ff) > CW'(OFF_MASK)) ? OFF_MASK : OB'(nursery_size_ff);

   assign req_fire    = req_tvalid && req_tready;
   assign req_payload = req_tdata[15:0];
   assign req_addr    = req_tdata[79:32];
   assign req_sc      = req_tdata[93:80];
   assign req_total   = (TW'(HEADER_BYTES) + TW'(req_payload) + TW'(7)) & ~TW'(7);
   assign bump_fit    = bump_en_ff && ((SUMW'(bump_off_ff) + SUMW'(req_total)) <= SUMW'(cap));

   // pin / unpin range check
   assign addr_above = {1'b0, req_addr} >= ({1'b0, heap_base_ff} + (AW+1)'(HEADER_BYTES));
   assign pin_start  = req_addr - heap_base_ff - AW'(HEADER_BYTES);
   assign pin_end    = {1'b0, pin_start} + (AW+1)'({req_sc, 3'b000});
   assign pin_inside = addr_above &&
      ((req_tuser == nbfa_pkg::REQ_PIN) ? (pin_end <= (AW+1)'(cap))
                                        : (pin_start < AW'(cap)));

   assign fr_start = f_rdata[FRAG_W-1:OB];
   assign fr_size  = f_rdata[OB-1:0];
   assign fr_nsize = fr_size - OB'(total_ff);
   assign pn_start = p_rdata[PIN_W-1:SCW];
   assign rs_cand  = p_rdata[PIN_W-1:SCW];
   assign idx_nx   = idx_ff + IW'(1);
   assign idx_m1   = idx_ff - IW'(1);

   // pinned region in sorted order, during the rebuild
   assign best_len  = TW'({best_sc_ff, 3'b000});
   assign best_end  = SUMW'(best_start_ff) + SUMW'(best_len);
   assign gap       = best_start_ff - prev_ff[OB-1:0];
   assign tail_size = cap - prev_ff[OB-1:0];
   assign tail_add  = (prev_ff < SUMW'(cap)) && (tail_size >= MIN_FRAG) &&
                      (fcnt_ff < FCNT_W'(MAX_FRAGMENTS));

   assign out_hdr = res_ok_ff ? (heap_base_ff + AW'(res_off_ff)) : '0;
   assign out_pay = res_ok_ff ? (out_hdr + AW'(HEADER_BYTES)) : '0;

   always_comb begin
      state_in        = state_ff;
      heap_base_in    = heap_base_ff;
      nursery_size_in = nursery_size_ff;
      bump_off_in     = bump_off_ff;
      used_in         = used_ff;
      bump_en_in      = bump_en_ff;
      fcnt_in         = fcnt_ff;
      pcnt_in         = pcnt_ff;
      op_in           = op_ff;
      total_in        = total_ff;
      tag_in          = tag_ff;
      pstart_in       = pstart_ff;
      psc_in          = psc_ff;
      idx_in          = idx_ff;
      round_in        = round_ff;
      prev_in         = prev_ff;
      sum_in          = sum_ff;
      last_in         = last_ff;
      have_last_in    = have_last_ff;
      best_v_in       = best_v_ff;
      best_start_in   = best_start_ff;
      best_sc_in      = best_sc_ff;
      first_start_in  = first_start_ff;
      res_status_in   = res_status_ff;
      res_off_in      = res_off_ff;
      res_ok_in       = res_ok_ff;
      res_frag_in     = res_frag_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_user_in     = rsp_user_ff;
      f_we    = 1'b0;
      f_waddr = '0;
      f_wdata = '0;
      f_raddr = idx_ff[FIDX_W-1:0];
      p_we    = 1'b0;
      p_waddr = '0;
      p_wdata = '0;
      p_raddr = idx_ff[PIDX_W-1:0];

      if (csr_valid) begin
         if (csr_index == nbfa_pkg::CSR_HEAP_BASE) begin
            heap_base_in = csr_data;
         end else begin
            nursery_size_in = csr_data[NSW-1:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_tuser;
               tag_in        = req_tdata[31:16];
               total_in      = req_total;
               pstart_in     = pin_start[OB-1:0];
               psc_in        = req_sc;
               res_status_in = nbfa_pkg::ST_OK;
               res_ok_in     = 1'b0;
               res_frag_in   = 1'b0;
               res_off_in    = '0;
               idx_in        = '0;
               state_in      = S_DONE;
               case (req_tuser) inside
                  nbfa_pkg::REQ_ALLOC: begin
                     if (bump_fit) begin
                        res_ok_in   = 1'b1;
                        res_off_in  = bump_off_ff;
                        bump_off_in = bump_off_ff + OB'(req_total);
                        used_in     = sat_add(used_ff, req_total);
                     end else if (fcnt_ff == '0) begin
                        res_status_in = nbfa_pkg::ST_NOSPACE;
                     end else begin
                        state_in = S_FR_RD;
                     end
                  end
                  nbfa_pkg::REQ_PIN, nbfa_pkg::REQ_UNPIN: begin
                     if (!pin_inside) begin
                        res_status_in = nbfa_pkg::ST_OUTSIDE;
                     end else if (pcnt_ff == '0) begin
                        state_in = S_PN_MISS;
                     end else begin
                        state_in = S_PN_RD;
                     end
                  end
                  default: begin
                     // nursery reset
                     fcnt_in = '0;
                     if (pcnt_ff == '0) begin
                        bump_off_in = '0;
                        used_in     = '0;
                        bump_en_in  = 1'b1;
                     end else begin
                        prev_in      = '0;
                        sum_in       = '0;
                        have_last_in = 1'b0;
                        best_v_in    = 1'b0;
                        round_in     = '0;
                        state_in     = S_RS_RD;
                     end
                  end
               endcase
            end
         end

         S_FR_RD: state_in = S_FR_CHK;

         S_FR_CHK: begin
            if (SUMW'(fr_size) >= SUMW'(total_ff)) begin
               res_ok_in   = 1'b1;
               res_frag_in = 1'b1;
               res_off_in  = fr_start;
               used_in     = sat_add(used_ff, total_ff);
               if (fr_nsize >= MIN_FRAG) begin
                  f_we     = 1'b1;
                  f_waddr  = idx_ff[FIDX_W-1:0];
                  f_wdata  = {fr_start + OB'(total_ff), fr_nsize};
                  state_in = S_DONE;
               end else if (idx_nx < IW'(fcnt_ff)) begin
                  idx_in   = idx_nx;
                  state_in = S_FR_MV_RD;
               end else begin
                  fcnt_in  = fcnt_ff - FCNT_W'(1);
                  state_in = S_DONE;
               end
            end else if (idx_nx == IW'(fcnt_ff)) begin
               res_status_in = nbfa_pkg::ST_NOSPACE;
               state_in      = S_DONE;
            end else begin
               idx_in   = idx_nx;
               state_in = S_FR_RD;
            end
         end

         S_FR_MV_RD: state_in = S_FR_MV_WR;

         S_FR_MV_WR: begin
            // close the gap left by the removed fragment
            f_we    = 1'b1;
            f_waddr = idx_m1[FIDX_W-1:0];
            f_wdata = f_rdata;
            if (idx_nx == IW'(fcnt_ff)) begin
               fcnt_in  = fcnt_ff - FCNT_W'(1);
               state_in = S_DONE;
            end else begin
               idx_in   = idx_nx;
               state_in = S_FR_MV_RD;
            end
         end

         S_PN_RD: state_in = S_PN_CHK;

         S_PN_CHK: begin
            if (pn_start == pstart_ff) begin
               if (op_ff == nbfa_pkg::REQ_PIN) begin
                  state_in = S_DONE;
               end else if (idx_nx < IW'(pcnt_ff)) begin
                  idx_in   = idx_nx;
                  state_in = S_PN_MV_RD;
               end else begin
                  pcnt_in  = pcnt_ff - PCNT_W'(1);
                  state_in = S_DONE;
               end
            end else if (idx_nx == IW'(pcnt_ff)) begin
               state_in = S_PN_MISS;
            end else begin
               idx_in   = idx_nx;
               state_in = S_PN_RD;
            end
         end

         S_PN_MV_RD: state_in = S_PN_MV_WR;

         S_PN_MV_WR: begin
            p_we    = 1'b1;
            p_waddr = idx_m1[PIDX_W-1:0];
            p_wdata = p_rdata;
            if (idx_nx == IW'(pcnt_ff)) begin
               pcnt_in  = pcnt_ff - PCNT_W'(1);
               state_in = S_DONE;
            end else begin
               idx_in   = idx_nx;
               state_in = S_PN_MV_RD;
            end
         end

         S_PN_MISS: begin
            // region not yet pinned
            if (op_ff == nbfa_pkg::REQ_PIN) begin
               if (pcnt_ff >= PCNT_W'(MAX_PINNED)) begin
                  res_status_in = nbfa_pkg::ST_FULL;
               end else begin
                  p_we    = 1'b1;
                  p_waddr = pcnt_ff[PIDX_W-1:0];
                  p_wdata = {pstart_ff, psc_ff};
                  pcnt_in = pcnt_ff + PCNT_W'(1);
               end
            end
            state_in = S_DONE;
         end

         S_RS_RD: state_in = S_RS_CHK;

         S_RS_CHK: begin
            // smallest start above the last one taken
            if ((!have_last_ff || rs_cand > last_ff) &&
                (!best_v_ff || rs_cand < best_start_ff)) begin
               best_v_in     = 1'b1;
               best_start_in = rs_cand;
               best_sc_in    = p_rdata[SCW-1:0];
            end
            if (idx_nx == IW'(pcnt_ff)) begin
               state_in = S_RS_APPLY;
            end else begin
               idx_in   = idx_nx;
               state_in = S_RS_RD;
            end
         end

         S_RS_APPLY: begin
            if (SUMW'(best_start_ff) > prev_ff && gap >= MIN_FRAG &&
                fcnt_ff < FCNT_W'(MAX_FRAGMENTS)) begin
               f_we    = 1'b1;
               f_waddr = fcnt_ff[FIDX_W-1:0];
               f_wdata = {prev_ff[OB-1:0], gap};
               if (fcnt_ff == '0) begin
                  first_start_in = prev_ff[OB-1:0];
               end
               fcnt_in = fcnt_ff + FCNT_W'(1);
            end
            if (best_end > prev_ff) begin
               prev_in = best_end;
            end
            sum_in       = sat_add(sum_ff, best_len);
            last_in      = best_start_ff;
            have_last_in = 1'b1;
            best_v_in    = 1'b0;
            idx_in       = '0;
            if (round_ff + PCNT_W'(1) == pcnt_ff) begin
               state_in = S_RS_TAIL;
            end else begin
               round_in = round_ff + PCNT_W'(1);
               state_in = S_RS_RD;
            end
         end

         S_RS_TAIL: begin
            if (tail_add) begin
               f_we    = 1'b1;
               f_waddr = fcnt_ff[FIDX_W-1:0];
               f_wdata = {prev_ff[OB-1:0], tail_size};
               fcnt_in = fcnt_ff + FCNT_W'(1);
            end
            if (fcnt_ff != '0) begin
               bump_off_in = first_start_ff;
            end else if (tail_add) begin
               bump_off_in = prev_ff[OB-1:0];
            end else begin
               bump_off_in = cap;
            end
            // bumping would run over pinned objects
            bump_en_in = 1'b0;
            used_in    = sum_ff;
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = RSP_W'({res_frag_ff, used_ff,
                                      res_ok_ff ? tag_ff : 16'd0,
                                      res_ok_ff ? total_ff[TW-1:3] : SCW'(0),
                                      out_hdr, out_pay});
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         heap_base_ff    <= '0;
         nursery_size_ff <= NSW'(1048576);
         bump_off_ff     <= '0;
         used_ff         <= '0;
         bump_en_ff      <= 1'b1;
         fcnt_ff         <= '0;
         pcnt_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         heap_base_ff    <= heap_base_in;
         nursery_size_ff <= nursery_size_in;
         bump_off_ff     <= bump_off_in;
         used_ff         <= used_in;
         bump_en_ff      <= bump_en_in;
         fcnt_ff         <= fcnt_in;
         pcnt_ff         <= pcnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      op_ff          <= op_in;
      total_ff       <= total_in;
      tag_ff         <= tag_in;
      pstart_ff      <= pstart_in;
      psc_ff         <= psc_in;
      idx_ff         <= idx_in;
      round_ff       <= round_in;
      prev_ff        <= prev_in;
      sum_ff         <= sum_in;
      last_ff        <= last_in;
      have_last_ff   <= have_last_in;
      best_v_ff      <= best_v_in;
      best_start_ff  <= best_start_in;
      best_sc_ff     <= best_sc_in;
      first_start_ff <= first_start_in;
      res_status_ff  <= res_status_in;
      res_off_ff     <= res_off_in;
      res_ok_ff      <= res_ok_in;
      res_frag_ff    <= res_frag_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule
`default_nettype wire

>>> src/nbfa_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the fragment and pinned-region tables. No dependencies.
`default_nettype none
module nbfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                     wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                     rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> src/nbfa_checker.sv
// Port-level checks for the nursery allocator, bound to the top level.
// Depends on nbfa_pkg and nursery_bump_fragment_allocator_unit.
`default_nettype none
module nbfa_checker #(
   parameter int HEADER_BYTES = 16,
   parameter int RSP_W        = 152
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic [1:0]       rsp_tuser
);
   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // failures carry no addresses
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != nbfa_pkg::ST_OK |-> rsp_tdata[95:0] == 96'd0)
      else $error("failed item carries an address");

   // payload sits right after the header
   a_pay_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[47:0] != 48'd0 || rsp_tdata[95:48] != 48'd0) |->
      rsp_tdata[47:0] == rsp_tdata[95:48] + 48'(HEADER_BYTES))
      else $error("payload and header addresses disagree");

   // taking an item lowers req_tready, so items are never taken back to back
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted back to back");
endmodule

bind nursery_bump_fragment_allocator_unit nbfa_checker #(
   .HEADER_BYTES(HEADER_BYTES),
   .RSP_W(((2*48 + 14 + 16 + OFFSET_BITS + 1 + 7) / 8) * 8)
) u_nbfa_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
`default_nettype wire

>>> tb/sv/tb_nursery_bump_fragment_allocator_unit.sv
// Testbench for the nursery bump/fragment allocator: stream driver, result monitor and
// a scoreboard class that predicts every result from its own copy of the allocator state.
// Depends on nbfa_pkg and the nursery_bump_fragment_allocator_unit RTL.
`timescale 1ns / 1ps

typedef struct {
   logic [1:0]  kind;
   logic [15:0] payload;
   logic [15:0] tag;
   logic [47:0] addr;
   logic [13:0] psc;
} alloc_req_type;

typedef struct {
   logic [1:0]  status;
   logic [47:0] pay;
   logic [47:0] hdr;
   logic [13:0] sc;
   logic [15:0] tag;
   logic [24:0] used;
   logic        ff;
} alloc_rsp_type;

class alloc_scoreboard;
   localparam longint unsigned HDR      = 16;
   localparam int              NPIN     = 16;
   localparam int              NFRAG    = 17;
   localparam longint unsigned OFS_MASK = (64'd1 << 25) - 1;
   localparam longint unsigned A_MASK   = 64'hFFFF_FFFF_FFFF;

   longint unsigned base, nsize, bump, used;
   bit              bump_on;
   longint unsigned frag_start[NFRAG], frag_size[NFRAG];
   int              frag_n;
   longint unsigned pin_start[NPIN], pin_sc[NPIN];
   int              pin_n;
   alloc_rsp_type   expected_q[$];
   string           faults[$];

   function new();
      base = 0; nsize = 1048576; bump = 0; used = 0; bump_on = 1;
      frag_n = 0; pin_n = 0;
   endfunction

   function longint unsigned capacity();
      return (nsize > OFS_MASK) ? OFS_MASK : nsize;
   endfunction

   function void set_reg(logic idx, longint unsigned v);
      if (idx == nbfa_pkg::CSR_HEAP_BASE) base = v & A_MASK;
      else nsize = v & 64'h1FF_FFFF;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void add_fault(string msg);
      faults.insert(faults.size(), msg);
   endfunction

   function void add_frag(longint unsigned s, longint unsigned sz);
      if (sz >= HDR + 8 && frag_n < NFRAG) begin
         frag_start[frag_n] = s; frag_size[frag_n] = sz; frag_n++;
      end
   endfunction

   // rebuild fragments from the gaps between the sorted pinned regions
   function void rebuild();
      longint unsigned rs[NPIN], rc[NPIN];
      longint unsigned ks, kc, prev, cap, sum, e;
      int j;
      prev = 0; sum = 0; cap = capacity();
      frag_n = 0;
      if (pin_n == 0) begin
         bump = 0; used = 0; bump_on = 1;
         return;
      end
      for (int i = 0; i < NPIN; i++) begin rs[i] = pin_start[i]; rc[i] = pin_sc[i]; end
      for (int i = 1; i < pin_n; i++) begin
         ks = rs[i]; kc = rc[i]; j = i;
         while (j > 0 && rs[j-1] > ks) begin rs[j] = rs[j-1]; rc[j] = rc[j-1]; j--; end
         rs[j] = ks; rc[j] = kc;
      end
      for (int i = 0; i < pin_n; i++) begin
         e = rs[i] + rc[i] * 8;
         if (rs[i] > prev) add_frag(prev, rs[i] - prev);
         if (e > prev) prev = e;    // overlapping regions: gap starts at highest end
         sum += rc[i] * 8;
      end
      if (prev < cap) add_frag(prev, cap - prev);
      bump = frag_n ? frag_start[0] : cap;
      bump_on = 0;
      used = (sum > OFS_MASK) ? OFS_MASK : sum;
   endfunction

   function void note(alloc_req_type it);
      alloc_rsp_type   r;
      longint unsigned cap, total, off, obj, psc, st, s;
      bit              ok, in_range;
      int              found;
      r = '{default: '0};
      cap = capacity();
      case (it.kind) inside
         nbfa_pkg::REQ_ALLOC: begin
            total = (HDR + 64'(it.payload) + 7) & ~64'd7;
            ok = 0; off = 0;
            if (bump_on && bump + total <= cap) begin
               off = bump; bump += total; ok = 1;
            end else begin
               for (int i = 0; i < frag_n; i++) begin
                  if (frag_size[i] >= total) begin
                     off = frag_start[i];
                     frag_start[i] += total;
                     frag_size[i] -= total;
                     if (frag_size[i] < HDR + 8) begin
                        for (int k = i; k < frag_n - 1; k++) begin
                           frag_start[k] = frag_start[k+1]; frag_size[k] = frag_size[k+1];
                        end
                        frag_n--;
                     end
                     ok = 1; r.ff = 1;
                     break;
                  end
               end
            end
            if (ok) begin
               s = used + total;
               used = (s > OFS_MASK) ? OFS_MASK : s;
               r.hdr = 48'((base + off) & A_MASK);
               r.pay = 48'((base + off + HDR) & A_MASK);
               r.sc  = 14'(total / 8);
               r.tag = it.tag;
            end else r.status = nbfa_pkg::ST_NOSPACE;
         end
         nbfa_pkg::REQ_PIN, nbfa_pkg::REQ_UNPIN: begin
            obj = 64'(it.addr); psc = 64'(it.psc); st = 0;
            in_range = obj >= base + HDR;
            if (in_range) begin
               st = obj - base - HDR;
               if (it.kind == nbfa_pkg::REQ_PIN) in_range = st + psc * 8 <= cap;
               else in_range = st < cap;
            end
            if (!in_range) r.status = nbfa_pkg::ST_OUTSIDE;
            else begin
               found = pin_n;
               for (int i = 0; i < pin_n; i++)
                  if (pin_start[i] == st) begin found = i; break; end
               if (it.kind == nbfa_pkg::REQ_PIN) begin
                  if (found == pin_n) begin
                     if (pin_n >= NPIN) r.status = nbfa_pkg::ST_FULL;
                     else begin
                        pin_start[pin_n] = st; pin_sc[pin_n] = psc; pin_n++;
                     end
                  end
               end else if (found < pin_n) begin
                  for (int k = found; k < pin_n - 1; k++) begin
                     pin_start[k] = pin_start[k+1]; pin_sc[k] = pin_sc[k+1];
                  end
                  pin_n--;
               end
            end
         end
         default: rebuild();
      endcase
      r.used = used[24:0];
      expected_q.insert(expected_q.size(), r);
   endfunction

   function void check(alloc_rsp_type got);
      alloc_rsp_type w;
      w = expected_q.pop_front();
      if (got.status !== w.status)
         add_fault($sformatf("status got %0d want %0d", got.status, w.status));
      if (got.pay !== w.pay)
         add_fault($sformatf("payload_address got %h want %h", got.pay, w.pay));
      if (got.hdr !== w.hdr)
         add_fault($sformatf("header_address got %h want %h", got.hdr, w.hdr));
      if (got.sc !== w.sc)
         add_fault($sformatf("size_class_out got %0d want %0d", got.sc, w.sc));
      if (got.tag !== w.tag)
         add_fault($sformatf("type_tag got %h want %h", got.tag, w.tag));
      if (got.used !== w.used)
         add_fault($sformatf("used_bytes got %0d want %0d", got.used, w.used));
      if (got.ff !== w.ff)
         add_fault($sformatf("from_fragment got %0d want %0d", got.ff, w.ff));
   endfunction
endclass

module tb_nursery_bump_fragment_allocator_unit;
   localparam int LIMIT = 4000000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic [1:0]   req_tuser = nbfa_pkg::REQ_ALLOC;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [151:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic         csr_index = nbfa_pkg::CSR_HEAP_BASE;
   logic [47:0]  csr_data = '0;

   nursery_bump_fragment_allocator_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   alloc_scoreboard sb = new();

   int          errors = 0;
   int          n_items = 0;
   int          n_results = 0;
   int          n_settings = 0;
   int          cycles = 0;
   int          burst_left = 4;
   bit          valid_up = 0;
   int          stall_mode = 0;
   int          stall_cnt = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("** nursery_bump_fragment_allocator_unit: FAILED **");
         $finish;
      end
   end

   task automatic report(input string msg);
      errors++;
      $display("mismatch @%0t: %s", $time, msg);
   endtask

   // result monitor; ready follows its own pattern, switching modes now and then
   always @(posedge clock) begin
      alloc_rsp_type r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            r.pay    = rsp_tdata[47:0];
            r.hdr    = rsp_tdata[95:48];
            r.sc     = rsp_tdata[109:96];
            r.tag    = rsp_tdata[125:110];
            r.used   = rsp_tdata[150:126];
            r.ff     = rsp_tdata[151];
            r.status = rsp_tuser;
            n_results++;
            if (sb.pending() == 0) report("result with nothing expected");
            else begin
               sb.check(r);
               while (sb.faults.size() != 0) report(sb.faults.pop_front());
            end
         end
         if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_cnt  = $urandom_range(8, 80);
         end
         stall_cnt--;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // offer one item, wait for the handshake, then maybe end the burst with a gap
   task automatic send_item(input alloc_req_type it);
      int gap;
      req_tvalid <= 1'b1;
      valid_up = 1;
      req_tuser  <= it.kind;
      req_tdata  <= {2'b00, it.psc, it.addr, it.tag, it.payload};
      do @(posedge clock); while (!req_tready);
      sb.note(it);
      n_items++;
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         valid_up = 0;
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
   endtask

   task automatic drain();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 0;
      end
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input longint unsigned v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v[47:0];
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, 64'(v[47:0]));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic alloc_req_type mk(logic [1:0] k, int unsigned pl, int unsigned tg,
                                        longint unsigned a, int unsigned c);
      alloc_req_type it;
      it.kind = k; it.payload = pl[15:0]; it.tag = tg[15:0];
      it.addr = a[47:0]; it.psc = c[13:0];
      return it;
   endfunction

   // random allocs/pins/unpins/resets; pins/unpins mostly well-formed in the nursery
   function automatic alloc_req_type rand_item();
      alloc_req_type   it;
      longint unsigned wide, cap, off;
      int unsigned     pick, p;
      cap  = sb.capacity();
      wide = {$urandom(), $urandom()};
      it.kind = nbfa_pkg::REQ_ALLOC;
      it.tag  = 16'($urandom());
      it.addr = wide[47:0];
      it.psc  = 14'($urandom_range(0, 8194));
      p = $urandom_range(0, 9);
      if (p < 7) it.payload = 16'($urandom_range(0, 200));
      else if (p < 9) it.payload = 16'($urandom_range(0, 4095));
      else it.payload = 16'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 55) it.kind = nbfa_pkg::REQ_ALLOC;
      else if (pick < 80) begin
         it.kind = nbfa_pkg::REQ_PIN;
         if ($urandom_range(0, 9) < 8) begin
            off = 64'($urandom_range(0, int'(cap)));
            if ($urandom_range(0, 3) != 0) off = off & ~64'd7;
            it.addr = 48'(sb.base + 16 + off);
            it.psc  = ($urandom_range(0, 9) < 8) ? 14'($urandom_range(0, 64))
                                                 : 14'($urandom_range(0, 8194));
         end
      end else if (pick < 92) begin
         it.kind = nbfa_pkg::REQ_UNPIN;
         if (sb.pin_n > 0 && $urandom_range(0, 9) < 7)
            it.addr = 48'(sb.base + 16 + sb.pin_start[$urandom_range(0, sb.pin_n - 1)]);
      end else it.kind = nbfa_pkg::REQ_RESET;
      return it;
   endfunction

   longint unsigned phase_base[6] = '{0, 48'hFFFF_FFFF_FFFF, 0, 48'h1000, 0, 0};
   longint unsigned phase_size[6] = '{0, 16777216, 4096, 65536, 0, 1048576};
   int              phase_len[6]  = '{40, 220, 250, 220, 200, 220};

   initial begin
      longint unsigned pins[$];
      longint unsigned b;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: small nursery so every path is reached quickly
      b = 48'h100;
      write_reg(nbfa_pkg::CSR_HEAP_BASE, b);
      write_reg(nbfa_pkg::CSR_NURSERY_SIZE, 2048);
      n_settings++;
      send_item(mk(nbfa_pkg::REQ_ALLOC, 0, 16'h0000, 0, 0));
      send_item(mk(nbfa_pkg::REQ_ALLOC, 65535, 16'hFFFF, 0, 0));    // too large: no space
      send_item(mk(nbfa_pkg::REQ_PIN, 0, 0, 0, 8));                 // below base: outside
      send_item(mk(nbfa_pkg::REQ_PIN, 0, 0, b + 16 + 512, 8));
      send_item(mk(nbfa_pkg::REQ_PIN, 0, 0, b + 16 + 512, 8));      // duplicate pin
      send_item(mk(nbfa_pkg::REQ_PIN, 0, 0, b + 16 + 520, 8));      // overlaps previous
      send_item(mk(nbfa_pkg::REQ_PIN, 0, 0, b + 16 + 2040, 8));     // runs past capacity
      send_item(mk(nbfa_pkg::REQ_UNPIN, 0, 0, b + 16 + 1000, 0));   // never pinned
      send_item(mk(nbfa_pkg::REQ_UNPIN, 0, 0, 5, 0));               // outside
      send_item(mk(nbfa_pkg::REQ_UNPIN, 0, 0, b + 16 + 2048, 0));   // at capacity: outside
      send_item(mk(nbfa_pkg::REQ_PIN, 0, 0, b + 16 + 1500, 4));
      send_item(mk(nbfa_pkg::REQ_PIN, 0, 0, 48'hFFFF_FFFF_FFFF, 14'h3FFF));
      send_item(mk(nbfa_pkg::REQ_RESET, 0, 0, 0, 0));               // rebuild from gaps
      send_item(mk(nbfa_pkg::REQ_ALLOC, 100, 16'h1234, 0, 0));
      send_item(mk(nbfa_pkg::REQ_ALLOC, 400, 16'hABCD, 0, 0));
      send_item(mk(nbfa_pkg::REQ_ALLOC, 380, 16'h5555, 0, 0));
      send_item(mk(nbfa_pkg::REQ_ALLOC, 8, 16'hAAAA, 0, 0));
      send_item(mk(nbfa_pkg::REQ_ALLOC, 65535, 16'hFFFF, 0, 0));
      send_item(mk(nbfa_pkg::REQ_UNPIN, 0, 0, b + 16 + 520, 0));
      send_item(mk(nbfa_pkg::REQ_UNPIN, 0, 0, b + 16 + 512, 0));
      send_item(mk(nbfa_pkg::REQ_UNPIN, 0, 0, b + 16 + 1500, 0));
      send_item(mk(nbfa_pkg::REQ_RESET, 0, 0, 0, 0));               // nothing pinned: clear
      send_item(mk(nbfa_pkg::REQ_ALLOC, 2000, 16'h0F0F, 0, 0));
      drain();

      for (int p = 0; p < 6; p++) begin
         // unpin what is left and clear the nursery before moving the window
         pins.delete();
         for (int i = 0; i < sb.pin_n; i++) pins.insert(pins.size(), sb.pin_start[i]);
         foreach (pins[i])
            send_item(mk(nbfa_pkg::REQ_UNPIN, 0, 0, sb.base + 16 + pins[i], 0));
         send_item(mk(nbfa_pkg::REQ_RESET, 0, 0, 0, 0));
         drain();
         b = phase_base[p];
         if (p == 2 || p == 4) b = {$urandom(), $urandom()};
         write_reg(nbfa_pkg::CSR_HEAP_BASE, b);
         write_reg(nbfa_pkg::CSR_NURSERY_SIZE,
                   (p == 4) ? longint'($urandom()) : phase_size[p]);
         n_settings++;
         for (int i = 0; i < phase_len[p]; i++) send_item(rand_item());
         drain();
      end

      repeat (40) @(posedge clock);
      $display("sent %0d items (allocate, pin, unpin, reset), checked %0d results", n_items,
               n_results);
      $display("across %0d nursery window settings, %0d mismatches", n_settings, errors);
      if (errors == 0 && sb.pending() == 0)
         $display("** nursery_bump_fragment_allocator_unit: PASSED **");
      else
         $display("** nursery_bump_fragment_allocator_unit: FAILED **");
      $finish;
   end
endmodule
